### design/xor_linear_basis_defines.svh
// Assertion macros shared by the checker of xor_linear_basis.
// No dependencies; included by name where assertions are written.
`ifndef XOR_LINEAR_BASIS_DEFINES_SVH
`define XOR_LINEAR_BASIS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define XLB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define XLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/xlb_pkg.sv
// Shared types and constants for the xor_linear_basis block.
// No dependencies; used by the interfaces, controller and datapath.
package xlb_pkg;

   localparam int VALUE_BITS = 61;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture a new transaction, start at the top row
      logic step;   // process the row whose read data is present
      logic emit;   // move the finished result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;      // current step ends the walk
      logic out_free;  // output register can take a result this cycle
   } sts_type;

endpackage

### design/xlb_chan_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on xlb_pkg for the payload width.
interface xlb_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [xlb_pkg::VALUE_BITS-1:0]   value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface xlb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [xlb_pkg::VALUE_BITS-1:0]   max_xor;
   logic                             added;

   modport source (output valid, output max_xor, output added, input ready);
   modport sink   (input valid, input max_xor, input added, output ready);
endinterface

### design/xlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xlb_ram #(
   parameter int WIDTH = 61,
   parameter int DEPTH = 61
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/xlb_ctrl.sv
// Controller state machine: accept, walk the rows, hand off the result.
// Depends on xlb_pkg for state, command and status types.
module xlb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xlb_pkg::sts_type  sts,
   output xlb_pkg::cmd_type  cmd
);

   xlb_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         xlb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = xlb_pkg::ST_WALK;
            end
         end
         xlb_pkg::ST_WALK: begin
            cmd.step = 1'b1;
            if (sts.last) begin
               state_in = xlb_pkg::ST_DONE;
            end
         end
         xlb_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = xlb_pkg::ST_IDLE;
            end
         end
         default: state_in = xlb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xlb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/xlb_dp.sv
// Datapath: running word, row index, row valid bits, basis RAM, output register.
// Depends on xlb_pkg and xlb_ram.
module xlb_dp #(
   parameter int WORD_BITS = 61
) (
   input  logic                             clock,
   input  logic                             reset,
   input  xlb_pkg::cmd_type                 cmd,
   output xlb_pkg::sts_type                 sts,
   input  logic                             req_op,
   input  logic [xlb_pkg::VALUE_BITS-1:0]   req_value,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [xlb_pkg::VALUE_BITS-1:0]   rsp_max_xor,
   output logic                             rsp_added
);

   localparam int IDX_W = $clog2(WORD_BITS);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(WORD_BITS - 1);

   logic [WORD_BITS-1:0]           x_ff;
   logic                           op_ff;
   logic                           added_ff;
   logic [IDX_W-1:0]               idx_ff;
   logic [WORD_BITS-1:0]           valid_ff;
   logic                           out_valid_ff;
   logic [xlb_pkg::VALUE_BITS-1:0] out_max_ff;
   logic                           out_added_ff;

   logic [63:0]                    value_ext;
   logic [63:0]                    x_ext;
   logic [IDX_W-1:0]               rd_addr;
   logic [WORD_BITS-1:0]           rd_data;
   logic [WORD_BITS-1:0]           row;
   logic                           bit_set;
   logic                           ins_slot;
   logic [WORD_BITS-1:0]           x_step;
   logic                           wr_en;

   xlb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_BITS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (x_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read runs one row ahead of the row being processed
   assign rd_addr   = cmd.load ? TOP_IDX : idx_ff - IDX_W'(1);
   assign value_ext = 64'(req_value);
   assign x_ext     = 64'(x_ff);

   // a row never written reads as empty
   assign row      = valid_ff[idx_ff] ? rd_data : '0;
   assign bit_set  = x_ff[idx_ff];
   assign ins_slot = (op_ff == xlb_pkg::OP_INSERT) && bit_set && !valid_ff[idx_ff];
   assign wr_en    = cmd.step && ins_slot;

   always_comb begin
      if (op_ff == xlb_pkg::OP_INSERT) begin
         x_step = bit_set ? (x_ff ^ row) : x_ff;
      end else begin
         x_step = bit_set ? x_ff : (x_ff ^ row);
      end
   end

   assign sts.last     = ins_slot || (idx_ff == '0);
   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= value_ext[WORD_BITS-1:0];
         op_ff    <= req_op;
         idx_ff   <= TOP_IDX;
         added_ff <= 1'b0;
      end else if (cmd.step) begin
         x_ff     <= x_step;
         added_ff <= ins_slot;
         idx_ff   <= idx_ff - IDX_W'(1);
      end
      if (cmd.emit) begin
         out_max_ff   <= (op_ff == xlb_pkg::OP_QUERY) ?
                         x_ext[xlb_pkg::VALUE_BITS-1:0] : '0;
         out_added_ff <= (op_ff == xlb_pkg::OP_INSERT) ? added_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_max_xor = out_max_ff;
   assign rsp_added   = out_added_ff;

endmodule

### design/xor_linear_basis.sv
// Top level of the GF(2) linear basis block: controller plus datapath.
// Depends on xlb_pkg, xlb_chan_ifs, xlb_ctrl, xlb_dp.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    op, value
//   rsp_ch    out   valid / ready    max_xor, added
//
// Steps: a transaction is captured, then the basis rows are walked from the
//   top bit down, then the result moves into the output register. An insert
//   that finds an empty slot stops there. The single read port of the row RAM
//   sets the pace.
// Reset: synchronous; clears the per-row valid bits, so the basis is
//   empty right away.
// Stalls: a held response sits in the output register while the next request
//   is accepted and walked; only the hand-off waits for rsp_ch.ready.
module xor_linear_basis #(
   parameter int WORD_BITS = 61
) (
   input  logic       clock,
   input  logic       reset,
   xlb_req_if.sink    req_ch,
   xlb_rsp_if.source  rsp_ch
);

   xlb_pkg::cmd_type cmd;   // controller commands to the datapath
   xlb_pkg::sts_type sts;   // datapath status back to the controller

   // sequencer: idle -> walk rows -> hand off
   xlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // running word, row RAM with valid bits, and the output register
   xlb_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_op      (req_ch.op),
      .req_value   (req_ch.value),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_max_xor (rsp_ch.max_xor),
      .rsp_added   (rsp_ch.added)
   );

endmodule

### design/xor_linear_basis_checker.sv
// Port-level checker for xor_linear_basis and its bind statement.
// Depends on xor_linear_basis_defines.svh and xlb_pkg.
`include "xor_linear_basis_defines.svh"

module xor_linear_basis_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [xlb_pkg::VALUE_BITS-1:0]   rsp_max_xor,
   input logic                             rsp_added
);

   // stalled response keeps its payload
   `XLB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_max_xor) && $stable(rsp_added), "stalled response changed")

   // insert answers carry no max, query answers carry no added flag
   `XLB_ASSERT_IMPL(a_rsp_excl, clock, reset, rsp_valid && rsp_added, rsp_max_xor == '0, "added and max_xor both set")

   // an accepted transaction keeps the block busy in the next cycle
   `XLB_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")

   // reset leaves no response pending
   `XLB_ASSERT_IMPL(a_rst_empty, clock, reset, $fell(reset), !rsp_valid, "response valid after reset")

endmodule

bind xor_linear_basis xor_linear_basis_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_max_xor (rsp_ch.max_xor),
   .rsp_added   (rsp_ch.added)
);
